/* src/bspline_point_evaluator_macros.svh */
// Assertion macros shared by the RTL. Each check samples on clk and is
// disabled while arst_n is low.
`ifndef BSPLINE_POINT_EVALUATOR_MACROS_SVH
`define BSPLINE_POINT_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BSPE_ASSERT_HOLD(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bspe assertion failed");
// Next-cycle implication.
`define BSPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bspe assertion failed");
`else
`define BSPE_ASSERT_HOLD(lbl, ante, cons)
`define BSPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/bspe_pkg.sv */
`default_nettype none
package bspe_pkg;
	localparam int MAX_POINTS_DEF = 32;
	localparam int MAX_DEGREE_DEF = 5;
	localparam int FRAC_BITS      = 16;
	localparam int BASIS_BITS     = 28;

	localparam int FUNC_W  = 2;
	localparam int SLOT_W  = 6;
	localparam int KNOT_W  = 17;
	localparam int COORD_W = 32;
	localparam int DEG_W   = 3;
	localparam int CNT_W   = 6;
	localparam int STAT_W  = 2;
	localparam int REG_W   = 2;

	localparam logic [FUNC_W-1:0] FN_KNOT  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POINT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_POS   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_DERIV = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;
	localparam logic [STAT_W-1:0] ST_DEGREE = 2'd3;

	localparam logic [REG_W-1:0] REG_DEGREE = 2'd0;
	localparam logic [REG_W-1:0] REG_COUNT  = 2'd1;

	localparam logic [DEG_W-1:0] DEGREE_RST = 3'd3;
	localparam logic [CNT_W-1:0] COUNT_RST  = 6'd4;
endpackage
`default_nettype wire

/* src/bspe_ram.sv */
`default_nettype none
module bspe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/bspline_point_evaluator.sv */
`default_nettype none
// B-spline point evaluator. A word on the input ports is taken at a rising edge
// with start high and busy low; func picks a knot write, a control point write,
// a position query or a first-derivative query. Exactly one result word comes
// back for every accepted word, shown on result_x, result_y and status for a
// single cycle while done is high; the receiver cannot stall, so capture it
// then. Writes and rejected queries answer in the cycle after acceptance. A
// query runs the Cox-de Boor recursion on one shared multiplier and one shared
// radix-2 divider (53 iterations per division, plus a load and a sign fix step)
// under a small sequencer, and busy stays high until its result is shown.
// A query first sets the level-zero basis of every knot span from the span
// test, then works through each recursion level entry by entry, dividing for
// every nonzero term, and last sums the weighted points (position) or the
// point differences, each coordinate divided by its knot span (derivative).
// Knots and points must be written before a query reads them; the stores have
// no reset. Configuration is written on cfg_we with cfg_index 0 for the degree
// and 1 for the point count; the user must write it only while the block is
// idle, as the block itself does not enforce this.
`include "bspline_point_evaluator_macros.svh"
module bspline_point_evaluator import bspe_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [REG_W-1:0]          cfg_index,
	input  logic [CNT_W-1:0]          cfg_wdata,
	input  logic                      start,
	output logic                      busy,
	output logic                      done,
	input  logic [FUNC_W-1:0]         func,
	input  logic [SLOT_W-1:0]         slot_index,
	input  logic [KNOT_W-1:0]         knot_value,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic [KNOT_W-1:0]         param_t,
	output logic signed [COORD_W-1:0] result_x,
	output logic signed [COORD_W-1:0] result_y,
	output logic [STAT_W-1:0]         status
);
	localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
	localparam int KAW   = $clog2(KNOT_DEPTH);
	localparam int PAW   = $clog2(MAX_POINTS);
	localparam int PT_W  = 2 * COORD_W;
	localparam int DIF_W = KNOT_W + 1;       // signed knot difference
	localparam int BV_W  = BASIS_BITS + 3;   // basis value, clamped to +-2^29
	localparam int MA_W  = 35;               // multiplier operand A
	localparam int MB_W  = BV_W;             // multiplier operand B
	localparam int PR_W  = MA_W + MB_W;
	localparam int DW    = 53;               // divider dividend magnitude
	localparam int DCW   = $clog2(DW + 1);
	localparam int Q_W   = DW + 1;
	localparam int SUM_W = Q_W + 1;
	localparam int ACC_W = 36 + $clog2(MAX_POINTS);

	localparam logic signed [BV_W-1:0]  BASIS_ONE = BV_W'(1) <<< BASIS_BITS;
	localparam logic signed [SUM_W-1:0] BASIS_LIM = SUM_W'(1) <<< (BASIS_BITS + 1);
	localparam logic signed [Q_W-1:0]   COEF_LIM  = Q_W'(1) <<< 33;
	localparam logic signed [PR_W-1:0]  RND_BIAS  = (PR_W'(1) <<< BASIS_BITS) - PR_W'(1);

	typedef enum logic [4:0] {
		S_IDLE, S_END, S_ENDW, S_L0A, S_L0B, S_L0C,
		S_K0, S_K1, S_K2, S_K3, S_K4, S_TA, S_TB,
		S_DLD, S_DIV, S_DEND, S_WR,
		S_P0, S_P1, S_MX, S_MY, S_AY,
		S_D0, S_D1, S_D2, S_D3, S_DX, S_DW, S_DACC, S_DN,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {PH_A, PH_B, PH_Q} phase_t;

	state_t                   state_q;
	phase_t                   ph_q;
	logic [DEG_W-1:0]         deg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [FUNC_W-1:0]        fn_q;
	logic [KNOT_W-1:0]        t_q;
	logic [DEG_W-1:0]         lvl_q;
	logic [DEG_W-1:0]         p_q;
	logic [KAW-1:0]           i_q;
	logic [KAW-1:0]           klast_q;
	logic [KAW-1:0]           lastpt_q;
	logic [KNOT_W-1:0]        uend_q;
	logic [KNOT_W-1:0]        ui_q;
	logic [KNOT_W-1:0]        uip_q;
	logic [KNOT_W-1:0]        ui1_q;
	logic [KNOT_W-1:0]        uip1_q;
	logic signed [BV_W-1:0]   bi_q;
	logic signed [BV_W-1:0]   bi1_q;
	logic [PT_W-1:0]          pt0_q;
	logic [PT_W-1:0]          pt1_q;
	logic signed [DIF_W-1:0]  den_q;
	logic signed [PR_W-1:0]   prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [MA_W-1:0]   coef_q;
	logic signed [ACC_W-1:0]  accx_q;
	logic signed [ACC_W-1:0]  accy_q;
	logic                     sat_q;
	logic                     cy_q;
	logic [DW-1:0]            dnum_q;
	logic [DIF_W-1:0]         drem_q;
	logic [DIF_W-1:0]         dden_q;
	logic                     dneg_q;
	logic [DCW-1:0]           dcnt_q;
	logic                     done_q;
	logic signed [COORD_W-1:0] rx_q;
	logic signed [COORD_W-1:0] ry_q;
	logic [STAT_W-1:0]        st_q;

	// Memory ports.
	logic [KAW-1:0]           kra;
	logic [KAW-1:0]           bra;
	logic [PAW-1:0]           pra;
	logic [KNOT_W-1:0]        kd;
	logic [BV_W-1:0]          bd;
	logic [PT_W-1:0]          pd;
	logic                     kwe;
	logic                     pwe;
	logic                     bwe;
	logic signed [BV_W-1:0]   bwd;

	// Datapath.
	logic                     accept;
	logic                     slot_ok_k;
	logic                     slot_ok_p;
	logic                     cfg_bad;
	logic                     deg_big;
	logic [KAW-1:0]           i_1;
	logic [KAW-1:0]           i_p;
	logic [KAW-1:0]           i_p1;
	logic [KAW-1:0]           i_d1;
	logic signed [DIF_W-1:0]  t_s;
	logic signed [DIF_W-1:0]  dif_a;
	logic signed [DIF_W-1:0]  dif_b;
	logic signed [DIF_W-1:0]  dif_k;
	logic signed [COORD_W:0]  dcoord;
	logic                     on0;
	logic signed [MA_W-1:0]   ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [PR_W-1:0]   prod_c;
	logic signed [PR_W-1:0]   num_s;
	logic signed [PR_W-1:0]   num_mag;
	logic signed [DIF_W-1:0]  dsr;
	logic signed [DIF_W-1:0]  dsr_mag;
	logic [DIF_W:0]           trial;
	logic                     trial_ge;
	logic signed [Q_W-1:0]    q_s;
	logic signed [PR_W-1:0]   wsum;
	logic signed [ACC_W-1:0]  w_c;
	logic signed [SUM_W-1:0]  sum_b;
	logic                     acc_x_ok;
	logic                     acc_y_ok;

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign result_x = rx_q;
	assign result_y = ry_q;
	assign status   = st_q;
	assign accept   = start && !busy;

	assign slot_ok_k = (int'(slot_index) < KNOT_DEPTH);
	assign slot_ok_p = (int'(slot_index) < MAX_POINTS);
	assign cfg_bad   = (deg_q == '0) || (int'(deg_q) > MAX_DEGREE) ||
		(cnt_q < CNT_W'(2)) || (int'(cnt_q) > MAX_POINTS);
	assign deg_big   = (CNT_W'(deg_q) >= cnt_q);

	// The knot and point stores are written straight from the input word at acceptance.
	assign kwe = accept && (func == FN_KNOT) && slot_ok_k;
	assign pwe = accept && (func == FN_POINT) && slot_ok_p;

	bspe_ram #(.WIDTH(KNOT_W), .DEPTH(KNOT_DEPTH)) u_knot_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (KAW'(slot_index)),
		.wdata (knot_value),
		.raddr (kra),
		.rdata (kd)
	);

	bspe_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
		.clk   (clk),
		.we    (pwe),
		.waddr (PAW'(slot_index)),
		.wdata ({point_x, point_y}),
		.raddr (pra),
		.rdata (pd)
	);

	bspe_ram #(.WIDTH(BV_W), .DEPTH(KNOT_DEPTH)) u_basis_ram (
		.clk   (clk),
		.we    (bwe),
		.waddr (i_q),
		.wdata (bwd),
		.raddr (bra),
		.rdata (bd)
	);

	// Index arithmetic; every sum stays below the knot depth.
	assign i_1  = i_q + KAW'(1);
	assign i_p  = i_q + KAW'(p_q);
	assign i_p1 = i_p + KAW'(1);
	assign i_d1 = i_q + KAW'(deg_q) + KAW'(1);

	assign t_s   = $signed({1'b0, t_q});
	assign dif_a = $signed({1'b0, uip_q}) - $signed({1'b0, ui_q});
	assign dif_b = $signed({1'b0, uip1_q}) - $signed({1'b0, ui1_q});
	assign dif_k = $signed({1'b0, kd}) - $signed({1'b0, ui1_q});

	// Point difference of the coordinate in work.
	always_comb begin
		if (cy_q) begin
			dcoord = $signed({pt1_q[COORD_W-1], pt1_q[COORD_W-1:0]}) -
				$signed({pt0_q[COORD_W-1], pt0_q[COORD_W-1:0]});
		end else begin
			dcoord = $signed({pt1_q[PT_W-1], pt1_q[PT_W-1:COORD_W]}) -
				$signed({pt0_q[PT_W-1], pt0_q[PT_W-1:COORD_W]});
		end
	end

	// Span test: half-open span, last span also closed at the final knot.
	assign on0 = ((t_q >= ui_q) && (t_q < kd)) || ((i_q == lastpt_q) && (t_q == uend_q));

	// Memory read addresses per state.
	always_comb begin
		kra = i_q;
		bra = i_q;
		pra = PAW'(i_q);
		unique case (state_q)
			S_END:   kra = klast_q;
			S_L0B:   kra = i_1;
			S_K1:    begin
				kra = i_p;
				bra = i_1;
			end
			S_K2:    kra = i_1;
			S_K3:    kra = i_p1;
			S_D0:    kra = i_1;
			S_D1:    begin
				kra = i_d1;
				pra = PAW'(i_1);
			end
			S_D2:    bra = i_1;
			default: ;
		endcase
	end

	// Shared multiplier operands.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_TA: begin
				ma = MA_W'(bi_q);
				mb = MB_W'(t_s - $signed({1'b0, ui_q}));
			end
			S_TB: begin
				ma = MA_W'(bi1_q);
				mb = MB_W'($signed({1'b0, uip1_q}) - t_s);
			end
			S_MX: begin
				ma = MA_W'($signed(pt0_q[PT_W-1:COORD_W]));
				mb = bi_q;
			end
			S_MY: begin
				ma = MA_W'($signed(pt0_q[COORD_W-1:0]));
				mb = bi_q;
			end
			S_DX: begin
				ma = MA_W'(dcoord);
				mb = MB_W'($signed({1'b0, deg_q}));
			end
			S_DW: begin
				ma = coef_q;
				mb = bi_q;
			end
			default: ;
		endcase
	end

	assign prod_c = ma * mb;

	// Divider operands; the coefficient dividend carries the fraction shift.
	assign num_s   = (ph_q == PH_Q) ? (prod_q <<< FRAC_BITS) : prod_q;
	assign num_mag = num_s[PR_W-1] ? -num_s : num_s;
	always_comb begin
		unique case (ph_q)
			PH_A:    dsr = dif_a;
			PH_B:    dsr = dif_b;
			default: dsr = den_q;
		endcase
	end
	assign dsr_mag  = dsr[DIF_W-1] ? -dsr : dsr;
	assign trial    = {drem_q, dnum_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, dden_q});
	assign q_s      = dneg_q ? -$signed({1'b0, dnum_q}) : $signed({1'b0, dnum_q});
	assign sum_b    = sum_q + SUM_W'(q_s);

	// Product over 2^28, truncated toward zero.
	assign wsum = prod_q + (prod_q[PR_W-1] ? RND_BIAS : '0);
	assign w_c  = ACC_W'(wsum >>> BASIS_BITS);

	// Basis value for the entry being finished: the span test at level zero,
	// the clamped sum above it.
	always_comb begin
		if (state_q == S_L0C) begin
			bwd = on0 ? BASIS_ONE : '0;
		end else if (sum_q > BASIS_LIM) begin
			bwd = BV_W'(BASIS_LIM);
		end else if (sum_q < -BASIS_LIM) begin
			bwd = BV_W'(-BASIS_LIM);
		end else begin
			bwd = BV_W'(sum_q);
		end
	end
	assign bwe = (state_q == S_L0C) || (state_q == S_WR);

	assign acc_x_ok = (accx_q[ACC_W-1:COORD_W-1] == '0) || (accx_q[ACC_W-1:COORD_W-1] == '1);
	assign acc_y_ok = (accy_q[ACC_W-1:COORD_W-1] == '0) || (accy_q[ACC_W-1:COORD_W-1] == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH_A;
			deg_q    <= DEGREE_RST;
			cnt_q    <= COUNT_RST;
			fn_q     <= FN_KNOT;
			t_q      <= '0;
			lvl_q    <= '0;
			p_q      <= '0;
			i_q      <= '0;
			klast_q  <= '0;
			lastpt_q <= '0;
			uend_q   <= '0;
			ui_q     <= '0;
			uip_q    <= '0;
			ui1_q    <= '0;
			uip1_q   <= '0;
			bi_q     <= '0;
			bi1_q    <= '0;
			pt0_q    <= '0;
			pt1_q    <= '0;
			den_q    <= '0;
			prod_q   <= '0;
			sum_q    <= '0;
			coef_q   <= '0;
			accx_q   <= '0;
			accy_q   <= '0;
			sat_q    <= 1'b0;
			cy_q     <= 1'b0;
			dnum_q   <= '0;
			drem_q   <= '0;
			dden_q   <= '0;
			dneg_q   <= 1'b0;
			dcnt_q   <= '0;
			done_q   <= 1'b0;
			rx_q     <= '0;
			ry_q     <= '0;
			st_q     <= ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEGREE: deg_q <= cfg_wdata[DEG_W-1:0];
					REG_COUNT:  cnt_q <= cfg_wdata;
					default:    ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rx_q <= '0;
						ry_q <= '0;
						fn_q <= func;
						t_q  <= param_t;
						if (func == FN_KNOT) begin
							done_q <= 1'b1;
							st_q   <= slot_ok_k ? ST_OK : ST_RANGE;
						end else if (func == FN_POINT) begin
							done_q <= 1'b1;
							st_q   <= slot_ok_p ? ST_OK : ST_RANGE;
						end else if (cfg_bad) begin
							done_q <= 1'b1;
							st_q   <= ST_RANGE;
						end else if (deg_big) begin
							done_q <= 1'b1;
							st_q   <= ST_DEGREE;
						end else begin
							// Launch a query: span search first.
							sat_q    <= 1'b0;
							p_q      <= '0;
							i_q      <= '0;
							lvl_q    <= (func == FN_POS) ? deg_q : (deg_q - DEG_W'(1));
							klast_q  <= KAW'(int'(cnt_q) + int'(deg_q));
							lastpt_q <= KAW'(int'(cnt_q) - 1);
							accx_q   <= '0;
							accy_q   <= '0;
							state_q  <= S_END;
						end
					end
				end
				S_END:  state_q <= S_ENDW;
				S_ENDW: begin
					uend_q  <= kd;
					state_q <= S_L0A;
				end
				S_L0A: state_q <= S_L0B;
				S_L0B: begin
					ui_q    <= kd;
					state_q <= S_L0C;
				end
				S_L0C: begin
					// Entry i takes its level-zero value from the span test here.
					if (i_q == klast_q - KAW'(1)) begin
						i_q <= '0;
						if (lvl_q == '0) begin
							state_q <= (fn_q == FN_POS) ? S_P0 : S_D0;
						end else begin
							p_q     <= DEG_W'(1);
							state_q <= S_K0;
						end
					end else begin
						i_q     <= i_1;
						state_q <= S_L0A;
					end
				end
				S_K0: state_q <= S_K1;
				S_K1: begin
					ui_q    <= kd;
					bi_q    <= $signed(bd);
					state_q <= S_K2;
				end
				S_K2: begin
					uip_q   <= kd;
					bi1_q   <= $signed(bd);
					state_q <= S_K3;
				end
				S_K3: begin
					ui1_q   <= kd;
					state_q <= S_K4;
				end
				S_K4: begin
					uip1_q  <= kd;
					state_q <= S_TA;
				end
				S_TA: begin
					sum_q <= '0;
					ph_q  <= PH_A;
					if ((dif_a != '0) && (bi_q != '0)) begin
						prod_q  <= prod_c;
						state_q <= S_DLD;
					end else begin
						state_q <= S_TB;
					end
				end
				S_TB: begin
					ph_q <= PH_B;
					if ((dif_b != '0) && (bi1_q != '0)) begin
						prod_q  <= prod_c;
						state_q <= S_DLD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_DLD: begin
					dnum_q  <= num_mag[DW-1:0];
					dden_q  <= dsr_mag;
					drem_q  <= '0;
					dneg_q  <= num_s[PR_W-1] ^ dsr[DIF_W-1];
					dcnt_q  <= DCW'(DW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					// One quotient bit per cycle.
					drem_q <= trial_ge ? DIF_W'(trial - {1'b0, dden_q}) : DIF_W'(trial);
					dnum_q <= {dnum_q[DW-2:0], trial_ge};
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == DCW'(1)) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: begin
					unique case (ph_q)
						PH_A: begin
							sum_q   <= SUM_W'(q_s);
							state_q <= S_TB;
						end
						PH_B: begin
							sum_q   <= sum_b;
							state_q <= S_WR;
						end
						default: begin
							if (q_s > COEF_LIM) begin
								coef_q <= MA_W'(COEF_LIM);
								sat_q  <= 1'b1;
							end else if (q_s < -COEF_LIM) begin
								coef_q <= MA_W'(-COEF_LIM);
								sat_q  <= 1'b1;
							end else begin
								coef_q <= MA_W'(q_s);
							end
							state_q <= S_DW;
						end
					endcase
				end
				S_WR: begin
					if ((sum_q > BASIS_LIM) || (sum_q < -BASIS_LIM)) begin
						sat_q <= 1'b1;
					end
					if (i_q == klast_q - KAW'(p_q) - KAW'(1)) begin
						i_q <= '0;
						if (p_q == lvl_q) begin
							state_q <= (fn_q == FN_POS) ? S_P0 : S_D0;
						end else begin
							p_q     <= p_q + DEG_W'(1);
							state_q <= S_K0;
						end
					end else begin
						i_q     <= i_1;
						state_q <= S_K0;
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					pt0_q   <= pd;
					bi_q    <= $signed(bd);
					state_q <= S_MX;
				end
				S_MX: begin
					prod_q  <= prod_c;
					state_q <= S_MY;
				end
				S_MY: begin
					accx_q  <= accx_q + w_c;
					prod_q  <= prod_c;
					state_q <= S_AY;
				end
				S_AY: begin
					accy_q <= accy_q + w_c;
					if (i_q == lastpt_q) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_1;
						state_q <= S_P0;
					end
				end
				S_D0: state_q <= S_D1;
				S_D1: begin
					ui1_q   <= kd;
					pt0_q   <= pd;
					state_q <= S_D2;
				end
				S_D2: begin
					den_q   <= dif_k;
					pt1_q   <= pd;
					state_q <= S_D3;
				end
				S_D3: begin
					bi_q <= $signed(bd);
					cy_q <= 1'b0;
					ph_q <= PH_Q;
					// Skip the term when its knot span is empty.
					state_q <= (den_q == '0) ? S_DN : S_DX;
				end
				S_DX: begin
					prod_q  <= prod_c;
					state_q <= S_DLD;
				end
				S_DW: begin
					prod_q  <= prod_c;
					state_q <= S_DACC;
				end
				S_DACC: begin
					if (cy_q) begin
						accy_q  <= accy_q + w_c;
						state_q <= S_DN;
					end else begin
						accx_q  <= accx_q + w_c;
						cy_q    <= 1'b1;
						state_q <= S_DX;
					end
				end
				S_DN: begin
					if (i_q == lastpt_q - KAW'(1)) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_1;
						state_q <= S_D0;
					end
				end
				S_FIN: begin
					// Saturate to 32 bits and show the result word.
					rx_q <= acc_x_ok ? accx_q[COORD_W-1:0] :
						(accx_q[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} :
						{1'b0, {(COORD_W-1){1'b1}}});
					ry_q <= acc_y_ok ? accy_q[COORD_W-1:0] :
						(accy_q[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} :
						{1'b0, {(COORD_W-1){1'b1}}});
					st_q    <= (sat_q || !acc_x_ok || !acc_y_ok) ? ST_SAT : ST_OK;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BSPE_ASSERT_HOLD(a_done_idle, done, !busy)
	`BSPE_ASSERT_HOLD(a_err_zero, done && (status == ST_RANGE || status == ST_DEGREE), result_x == 0 && result_y == 0)
	`BSPE_ASSERT_HOLD(a_level_bound, busy, p_q <= lvl_q)
	`BSPE_ASSERT_NEXT(a_div_flow, state_q == S_DIV, state_q == S_DIV || state_q == S_DEND)
endmodule
`default_nettype wire

/* verif/bspline_point_evaluator_tb.sv */
`timescale 1ns / 100ps
module bspline_point_evaluator_tb import bspe_pkg::*;;

	localparam int NPTS      = MAX_POINTS_DEF;
	localparam int NDEG      = MAX_DEGREE_DEF;
	localparam int NKNOTS    = NPTS + NDEG + 1;
	localparam int RAND_WORDS = 700;
	// Idle cycles with no word moving before the run is called hung.
	localparam int HANG_LIMIT = 400000;
	localparam longint BASIS_ONE = 64'sd1 <<< BASIS_BITS;
	localparam longint BASIS_CAP = 64'sd1 <<< 29;
	localparam longint COEF_CAP  = 64'sd1 <<< 33;
	localparam longint I32_MAX   = 64'sd2147483647;
	localparam longint I32_MIN   = -64'sd2147483648;

	typedef struct {
		logic [FUNC_W-1:0]  fn;
		logic [SLOT_W-1:0]  slot;
		logic [KNOT_W-1:0]  knot;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [KNOT_W-1:0]  t;
	} cmd_word_t;

	typedef struct {
		logic [COORD_W-1:0] rx;
		logic [COORD_W-1:0] ry;
		logic [STAT_W-1:0]  st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy, done;
	logic [FUNC_W-1:0] func = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [KNOT_W-1:0] knot_value = '0;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic [KNOT_W-1:0] param_t = '0;
	logic signed [COORD_W-1:0] result_x, result_y;
	logic [STAT_W-1:0] status;

	bspline_point_evaluator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .done(done),
		.func(func), .slot_index(slot_index), .knot_value(knot_value),
		.point_x(point_x), .point_y(point_y), .param_t(param_t),
		.result_x(result_x), .result_y(result_y), .status(status)
	);

	initial forever #2 clk = ~clk;

	// Shadow copy of the block: stores, registers and the basis scratch row.
	longint knot_mem [NKNOTS];
	longint px_mem [NPTS];
	longint py_mem [NPTS];
	longint basis_row [NKNOTS];
	int unsigned shadow_deg = DEGREE_RST;
	int unsigned shadow_cnt = COUNT_RST;
	bit clamp_hit;

	cmd_word_t pending_q[$];
	answer_t answer_q[$];
	cmd_word_t cur_word;
	int mismatches = 0;
	int hang_cnt = 0;

	function automatic longint clamp_to(longint v, longint lim);
		if (v > lim) begin
			clamp_hit = 1'b1;
			return lim;
		end
		if (v < -lim) begin
			clamp_hit = 1'b1;
			return -lim;
		end
		return v;
	endfunction

	// Cox-de Boor: leave N(i, level, t) in basis_row[i].
	function automatic void build_basis(longint t, int kc, int last_span, int level);
		longint u_end, a, b, sum;
		bit on;
		u_end = knot_mem[kc-1];
		for (int i = 0; i <= kc - 2; i++) begin
			a = knot_mem[i];
			b = knot_mem[i+1];
			on = (t >= a && t < b) || (i == last_span && t == u_end);
			basis_row[i] = on ? BASIS_ONE : 64'sd0;
		end
		for (int p = 1; p <= level; p++) begin
			for (int i = 0; i <= kc - 2 - p; i++) begin
				sum = 0;
				if (knot_mem[i+p] != knot_mem[i])
					sum += (t - knot_mem[i]) * basis_row[i] / (knot_mem[i+p] - knot_mem[i]);
				if (knot_mem[i+p+1] != knot_mem[i+1])
					sum += (knot_mem[i+p+1] - t) * basis_row[i+1] /
						(knot_mem[i+p+1] - knot_mem[i+1]);
				basis_row[i] = clamp_to(sum, BASIS_CAP);
			end
		end
	endfunction

	// Apply one word to the shadow state and return the answer it must produce.
	function automatic answer_t eval_word(cmd_word_t w);
		answer_t r;
		longint acc_x, acc_y, t, den, q;
		int deg, npts, kc;
		acc_x = 0;
		acc_y = 0;
		r.st = ST_OK;
		if (w.fn == FN_KNOT) begin
			if (w.slot < NKNOTS) knot_mem[w.slot] = longint'(w.knot);
			else r.st = ST_RANGE;
		end else if (w.fn == FN_POINT) begin
			if (w.slot < NPTS) begin
				px_mem[w.slot] = longint'($signed(w.px));
				py_mem[w.slot] = longint'($signed(w.py));
			end else begin
				r.st = ST_RANGE;
			end
		end else if (shadow_deg < 1 || shadow_deg > NDEG || shadow_cnt < 2 || shadow_cnt > NPTS) begin
			r.st = ST_RANGE;
		end else if (shadow_deg >= shadow_cnt) begin
			r.st = ST_DEGREE;
		end else begin
			deg = shadow_deg;
			npts = shadow_cnt;
			kc = npts + deg + 1;
			t = longint'(w.t);
			clamp_hit = 1'b0;
			if (w.fn == FN_POS) begin
				build_basis(t, kc, npts - 1, deg);
				for (int i = 0; i < npts; i++) begin
					acc_x += px_mem[i] * basis_row[i] / BASIS_ONE;
					acc_y += py_mem[i] * basis_row[i] / BASIS_ONE;
				end
			end else begin
				build_basis(t, kc, npts - 1, deg - 1);
				for (int i = 0; i < npts - 1; i++) begin
					den = knot_mem[i+deg+1] - knot_mem[i+1];
					if (den != 0) begin
						q = clamp_to((px_mem[i+1] - px_mem[i]) * deg * 65536 / den, COEF_CAP);
						acc_x += q * basis_row[i+1] / BASIS_ONE;
						q = clamp_to((py_mem[i+1] - py_mem[i]) * deg * 65536 / den, COEF_CAP);
						acc_y += q * basis_row[i+1] / BASIS_ONE;
					end
				end
			end
			if (acc_x > I32_MAX) begin acc_x = I32_MAX; clamp_hit = 1'b1; end
			if (acc_x < I32_MIN) begin acc_x = I32_MIN; clamp_hit = 1'b1; end
			if (acc_y > I32_MAX) begin acc_y = I32_MAX; clamp_hit = 1'b1; end
			if (acc_y < I32_MIN) begin acc_y = I32_MIN; clamp_hit = 1'b1; end
			if (clamp_hit) r.st = ST_SAT;
		end
		r.rx = acc_x[31:0];
		r.ry = acc_y[31:0];
		return r;
	endfunction

	// Driver: hold a word until start && !busy takes it, then predict and
	// advance. Bursts of random length alternate with random gaps.
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) answer_q.insert(answer_q.size(), eval_word(cur_word));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_word = pending_q.pop_front();
					func <= cur_word.fn;
					slot_index <= cur_word.slot;
					knot_value <= cur_word.knot;
					point_x <= cur_word.px;
					point_y <= cur_word.py;
					param_t <= cur_word.t;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks a result word for exactly one cycle; compare it.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word x=%h y=%h st=%0d", result_x, result_y, status);
			end else begin
				want = answer_q.pop_front();
				if (result_x !== want.rx || result_y !== want.ry || status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got x=%h y=%h st=%0d, want x=%h y=%h st=%0d",
							result_x, result_y, status, want.rx, want.ry, want.st);
				end
			end
		end
	end

	// Watchdog: count cycles in which no word moves either way.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) hang_cnt = 0;
			else hang_cnt++;
			if (hang_cnt >= HANG_LIMIT) begin
				$display("bspline_point_evaluator_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] slot, logic [KNOT_W-1:0] knot,
			logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [KNOT_W-1:0] t);
		cmd_word_t w;
		w.fn = fn;
		w.slot = slot;
		w.knot = knot;
		w.px = px;
		w.py = py;
		w.t = t;
		pending_q.insert(pending_q.size(), w);
	endtask

	// Hold until every word is taken and answered, then let the block settle.
	// Sample on the falling edge so the driver's updates have landed.
	task automatic drain;
		@(negedge clk);
		while (pending_q.size() > 0 || answer_q.size() > 0 || start || busy) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_W-1:0] idx, logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_DEGREE) shadow_deg = val & 6'h7;
		else if (idx == REG_COUNT) shadow_cnt = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] rand_coord;
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
			default: return $urandom;
		endcase
	endfunction

	int kv [NKNOTS];
	int kc_now;

	// Lay out a knot vector of kc entries; mostly sorted, sometimes clamped,
	// now and then raw noise (out of order, above 1.0).
	task automatic load_knots(int kc, int deg);
		int v, mode;
		mode = $urandom_range(0, 9);
		v = 0;
		for (int i = 0; i < kc; i++) begin
			if (mode == 0) begin
				v = $urandom_range(0, 131071);
			end else if (mode < 5 && i <= deg) begin
				v = 0;
			end else if (mode < 5 && i >= kc - 1 - deg) begin
				v = 65536;
			end else begin
				v += $urandom_range(0, 2 * 65536 / kc);
				if (v > 65536) v = 65536;
			end
			kv[i] = v;
			send(FN_KNOT, i, v, $urandom, $urandom, $urandom);
		end
	endtask

	function automatic logic [KNOT_W-1:0] pick_t;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: return kv[$urandom_range(0, kc_now - 1)];
			4, 5, 6: return kv[kc_now - 1];
			7: return 0;
			8: return 65536;
			9: return $urandom_range(0, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	int words_sent = 0;

	initial begin
		int deg, cnt, n, r, sel;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every knot and point store entry once so no query ever reads an unwritten one.
		for (int i = 0; i < NKNOTS; i++) begin
			kv[i] = (i < 4) ? 0 : ((i < 8) ? 65536 : i * 1700);
			send(FN_KNOT, i, kv[i], '0, '0, '0);
		end
		for (int i = 0; i < NPTS; i++)
			send(FN_POINT, i, '0, rand_coord(), rand_coord(), '0);
		kc_now = 8;
		drain();

		// Directed: reset configuration, extremes and the error cases.
		send(FN_POS, 0, 0, 0, 0, 0);
		send(FN_POS, 0, 0, 0, 0, 65536);
		send(FN_POS, 0, 0, 0, 0, 32768);
		send(FN_DERIV, 0, 0, 0, 0, 0);
		send(FN_DERIV, 0, 0, 0, 0, 65536);
		send(FN_POS, 0, 0, 0, 0, 17'h1FFFF);
		send(FN_KNOT, 37, 17'h1FFFF, 0, 0, 0);
		send(FN_KNOT, 38, 100, 0, 0, 0);
		send(FN_KNOT, 63, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
		send(FN_POINT, 32, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(FN_POINT, 63, 0, 0, 0, 0);
		send(FN_POINT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send(FN_POINT, 1, 0, 32'h8000_0000, 32'h8000_0000, 0);
		send(FN_POINT, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(FN_POINT, 3, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send(FN_POS, 0, 0, 0, 0, 40000);
		send(FN_DERIV, 0, 0, 0, 0, 40000);
		drain();
		// Degree not below point count, then out-of-range registers.
		write_reg(REG_DEGREE, 5);
		write_reg(REG_COUNT, 5);
		send(FN_POS, 0, 0, 0, 0, 100);
		drain();
		write_reg(REG_COUNT, 1);
		send(FN_DERIV, 0, 0, 0, 0, 100);
		drain();
		write_reg(REG_DEGREE, 0);
		write_reg(REG_COUNT, 63);
		send(FN_POS, 0, 0, 0, 0, 100);
		drain();
		write_reg(REG_DEGREE, 7);
		write_reg(2'd2, 6'h3F);
		write_reg(2'd3, 6'h2A);
		send(FN_DERIV, 0, 0, 0, 0, 100);
		drain();

		// Random phases: new registers, a fresh knot vector when they are valid, then mixed words.
		while (words_sent < RAND_WORDS) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				deg = 5; cnt = 32;
			end else if (sel == 1) begin
				deg = 1; cnt = 2;
			end else if (sel == 2) begin
				deg = $urandom_range(0, 1) ? 0 : $urandom_range(6, 7);
				cnt = $urandom_range(0, 63);
			end else if (sel == 3) begin
				deg = $urandom_range(1, 5);
				cnt = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
			end else if (sel == 4) begin
				deg = $urandom_range(2, 5);
				cnt = $urandom_range(2, deg);
			end else begin
				deg = $urandom_range(1, 3);
				cnt = $urandom_range(deg + 1, 6);
			end
			write_reg(REG_DEGREE, deg);
			write_reg(REG_COUNT, cnt);
			if (deg >= 1 && deg <= 5 && cnt >= 2 && cnt <= 32) begin
				kc_now = cnt + deg + 1;
				load_knots(kc_now, deg);
				words_sent += kc_now;
			end else begin
				kc_now = 8;
				for (int i = 0; i < 8; i++) kv[i] = i * 9000;
			end
			// Keep full-size phases short: each query there is slow.
			n = (cnt > 12 && cnt <= 32) ? 6 : 30;
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 35 && !(cnt > 12 && cnt <= 32 && k % 2 == 0)) begin
					send($urandom_range(0, 1) ? FN_POS : FN_DERIV, $urandom, $urandom,
						$urandom, $urandom, pick_t());
				end else if (r < 70) begin
					send(FN_POINT, $urandom_range(0, (cnt >= 2 && cnt <= 32) ? cnt - 1 : 31),
						$urandom, rand_coord(), rand_coord(), $urandom);
				end else if (r < 78) begin
					send(FN_KNOT, $urandom_range(0, kc_now - 1), $urandom_range(0, 65536),
						$urandom, $urandom, $urandom);
				end else if (r < 88) begin
					if ($urandom_range(0, 1))
						send(FN_KNOT, $urandom_range(NKNOTS, 63), $urandom, $urandom,
							$urandom, $urandom);
					else
						send(FN_POINT, $urandom_range(NPTS, 63), $urandom, $urandom,
							$urandom, $urandom);
				end else begin
					send(FN_POINT, $urandom_range(0, NPTS - 1), $urandom, rand_coord(),
						rand_coord(), $urandom);
				end
			end
			words_sent += n;
			drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("bspline_point_evaluator_tb: PASS");
		end else begin
			$display("bspline_point_evaluator_tb: FAIL");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/bspe_pkg.sv
src/bspe_ram.sv
src/bspline_point_evaluator.sv
verif/bspline_point_evaluator_tb.sv
